// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker in pinlk_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define PINLK_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define PINLK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pinlk_pkg.sv =====
package pinlk_pkg;

  // Event codes on the input beat.
  typedef enum logic [1:0] {
    CMD_DIGIT = 2'd0,
    CMD_BACK  = 2'd1,
    CMD_ENTER = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  // Status codes on the result beat.
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_INCOMPLETE = 3'd1;
  localparam logic [2:0] STS_GRANTED    = 3'd2;
  localparam logic [2:0] STS_WRONG      = 3'd3;
  localparam logic [2:0] STS_LOCKED     = 3'd4;
  localparam logic [2:0] STS_IGNORED    = 3'd5;
  localparam logic [2:0] STS_UNLOCKED   = 3'd6;
  localparam logic [2:0] STS_COUNTING   = 3'd7;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_HASH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 2'd2;

  // Register reset values.
  localparam logic [31:0] RST_PIN_HASH      = 32'h6222_E842;
  localparam logic [3:0]  RST_ATTEMPT_LIMIT = 4'd3;
  localparam logic [7:0]  RST_LOCKOUT_TICKS = 8'd30;

  // Hash constants. The prime 0x01000193 has set bits at 0, 1, 4, 7, 8 and 24,
  // so one multiply is six shifted adds.
  localparam int          HASH_W      = 32;
  localparam logic [31:0] FNV_BASIS   = 32'h811C_9DC5;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam int          PRIME_TERMS = 6;
  localparam logic [2:0]  LAST_TERM   = 3'(PRIME_TERMS - 1);

  function automatic logic [4:0] prime_shift(input logic [2:0] term);
    logic [4:0] sh;
    unique case (term)
      3'd0:    sh = 5'd0;
      3'd1:    sh = 5'd1;
      3'd2:    sh = 5'd4;
      3'd3:    sh = 5'd7;
      3'd4:    sh = 5'd8;
      3'd5:    sh = 5'd24;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

  // Controller sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_CHECK,
    S_PUT
  } top_state_t;

  // Hash unit states.
  typedef enum logic [1:0] {
    H_IDLE,
    H_XOR,
    H_MUL
  } hash_state_t;

  // What the hash unit reports back to the controller.
  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] value;
  } hash_res_t;

endpackage

// ===== rtl/pinlk_hash.sv =====
module pinlk_hash #(
  parameter int PIN_DIGITS = 4,
  localparam int IdxW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [3:0]           digit,
  output logic [IdxW-1:0]      idx,
  output pinlk_pkg::hash_res_t res
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PIN_DIGITS - 1);

  pinlk_pkg::hash_state_t state, state_next;

  logic [2:0]                   term;
  logic [pinlk_pkg::HASH_W-1:0] h;
  logic [pinlk_pkg::HASH_W-1:0] m;
  logic [pinlk_pkg::HASH_W-1:0] acc;
  logic [pinlk_pkg::HASH_W-1:0] partial;
  logic [pinlk_pkg::HASH_W-1:0] char_word;
  logic                         last_term;

  // One shifted copy of the operand per cycle.
  assign partial   = m << pinlk_pkg::prime_shift(term);
  assign last_term = (term == pinlk_pkg::LAST_TERM);
  assign char_word = pinlk_pkg::HASH_W'(pinlk_pkg::ASCII_ZERO + {4'b0000, digit});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pinlk_pkg::H_IDLE: begin
        if (start) state_next = pinlk_pkg::H_XOR;
      end
      pinlk_pkg::H_XOR: begin
        state_next = pinlk_pkg::H_MUL;
      end
      pinlk_pkg::H_MUL: begin
        if (last_term) begin
          state_next = (idx == LastIdx) ? pinlk_pkg::H_IDLE : pinlk_pkg::H_XOR;
        end
      end
      default: state_next = pinlk_pkg::H_IDLE;
    endcase
  end

  // Outputs: done pulses as the last product of the last character lands.
  always_comb begin
    res.done  = (state == pinlk_pkg::H_MUL) && last_term && (idx == LastIdx);
    res.value = h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pinlk_pkg::H_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: fold in one character, then six shifted adds for the multiply.
  always_ff @(posedge clk) begin
    unique case (state)
      pinlk_pkg::H_IDLE: begin
        if (start) begin
          h   <= pinlk_pkg::FNV_BASIS;
          idx <= '0;
        end
      end
      pinlk_pkg::H_XOR: begin
        m    <= h ^ char_word;
        acc  <= '0;
        term <= 3'd0;
      end
      pinlk_pkg::H_MUL: begin
        if (last_term) begin
          h   <= acc + partial;
          idx <= idx + IdxW'(1);
        end else begin
          acc  <= acc + partial;
          term <= term + 3'd1;
        end
      end
      default: begin
        term <= 3'd0;
      end
    endcase
  end

endmodule

// ===== rtl/pin_entry_lockout_controller_unit.sv =====
// A beat that does not check the PIN goes from S_IDLE through S_PUT to the result register;
// a check goes through S_HASH, S_CHECK and S_PUT. No new beat is taken until the sequencer is
// back in S_IDLE, and a check waits on the hash unit, which takes one character and then one
// shifted add of the prime per cycle.
// Reset (synchronous, active high) restores the register defaults, empties the digit count,
// clears attempts and lockout, and drops the result beat; the digit store is not cleared.
module pin_entry_lockout_controller_unit #(
  parameter int PIN_DIGITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pinlk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pinlk_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      cmd,
  input  logic [3:0]                      key_digit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [2:0]                      digits_held,
  output logic [3:0]                      attempts_used,
  output logic                            is_locked,
  output logic [7:0]                      lock_remaining
);

  localparam int IdxW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int CntW = $clog2(PIN_DIGITS + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(PIN_DIGITS);
  localparam logic [CntW-1:0] LastCount = CntW'(PIN_DIGITS - 1);

  // Configuration registers.
  logic [31:0] pin_hash;
  logic [3:0]  attempt_limit;
  logic [7:0]  lockout_ticks;

  // Controller state.
  pinlk_pkg::top_state_t state, state_next;
  logic [3:0]      digit_store [PIN_DIGITS];
  logic [CntW-1:0] digit_count, digit_count_next;
  logic [3:0]      attempt_count, attempt_count_next;
  logic            lock_flag, lock_flag_next;
  logic [7:0]      lock_counter, lock_counter_next;
  logic [2:0]      pend_status, pend_status_next;

  logic            in_accept;
  logic            need_check;
  logic            store_we;
  logic            out_load;
  logic            hash_start;
  logic [3:0]      attempt_inc;
  logic [IdxW-1:0] hash_idx;
  pinlk_pkg::hash_res_t hash_res;

  assign in_accept   = in_valid && !in_stall;
  assign attempt_inc = (attempt_count == 4'hF) ? 4'hF : attempt_count + 4'd1;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_hash      <= pinlk_pkg::RST_PIN_HASH;
      attempt_limit <= pinlk_pkg::RST_ATTEMPT_LIMIT;
      lockout_ticks <= pinlk_pkg::RST_LOCKOUT_TICKS;
    end else if (cfg_we) begin
      if (cfg_index == pinlk_pkg::REG_PIN_HASH)      pin_hash      <= cfg_data;
      if (cfg_index == pinlk_pkg::REG_ATTEMPT_LIMIT) attempt_limit <= cfg_data[3:0];
      if (cfg_index == pinlk_pkg::REG_LOCKOUT_TICKS) lockout_ticks <= cfg_data[7:0];
    end
  end

  // Event decode and the outcome of a check.
  always_comb begin
    digit_count_next   = digit_count;
    attempt_count_next = attempt_count;
    lock_flag_next     = lock_flag;
    lock_counter_next  = lock_counter;
    pend_status_next   = pend_status;
    need_check         = 1'b0;
    store_we           = 1'b0;
    unique case (state)
      pinlk_pkg::S_IDLE: begin
        if (cmd == pinlk_pkg::CMD_TICK) begin
          if (!lock_flag) begin
            pend_status_next = pinlk_pkg::STS_IGNORED;
          end else if (lock_counter <= 8'd1) begin
            lock_counter_next  = 8'd0;
            lock_flag_next     = 1'b0;
            attempt_count_next = 4'd0;
            pend_status_next   = pinlk_pkg::STS_UNLOCKED;
          end else begin
            lock_counter_next = lock_counter - 8'd1;
            pend_status_next  = pinlk_pkg::STS_COUNTING;
          end
        end else if (lock_flag) begin
          pend_status_next = pinlk_pkg::STS_IGNORED;
        end else if (cmd == pinlk_pkg::CMD_DIGIT) begin
          if (digit_count < FullCount) begin
            store_we         = 1'b1;
            digit_count_next = digit_count + CntW'(1);
            need_check       = (digit_count == LastCount);
            pend_status_next = pinlk_pkg::STS_OK;
          end else begin
            pend_status_next = pinlk_pkg::STS_IGNORED;
          end
        end else if (cmd == pinlk_pkg::CMD_BACK) begin
          if (digit_count != '0) digit_count_next = digit_count - CntW'(1);
          pend_status_next = pinlk_pkg::STS_OK;
        end else begin
          if (digit_count < FullCount) begin
            pend_status_next = pinlk_pkg::STS_INCOMPLETE;
          end else begin
            need_check = 1'b1;
          end
        end
      end
      pinlk_pkg::S_CHECK: begin
        digit_count_next = '0;
        if (hash_res.value == pin_hash) begin
          attempt_count_next = 4'd0;
          pend_status_next   = pinlk_pkg::STS_GRANTED;
        end else begin
          attempt_count_next = attempt_inc;
          if (attempt_inc >= attempt_limit) begin
            lock_flag_next    = 1'b1;
            lock_counter_next = lockout_ticks;
            pend_status_next  = pinlk_pkg::STS_LOCKED;
          end else begin
            pend_status_next = pinlk_pkg::STS_WRONG;
          end
        end
      end
      default: begin
        need_check = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pinlk_pkg::S_IDLE: begin
        if (in_accept) state_next = need_check ? pinlk_pkg::S_HASH : pinlk_pkg::S_PUT;
      end
      pinlk_pkg::S_HASH: begin
        if (hash_res.done) state_next = pinlk_pkg::S_CHECK;
      end
      pinlk_pkg::S_CHECK: begin
        state_next = pinlk_pkg::S_PUT;
      end
      pinlk_pkg::S_PUT: begin
        if (!out_valid || !out_stall) state_next = pinlk_pkg::S_IDLE;
      end
      default: state_next = pinlk_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall   = (state != pinlk_pkg::S_IDLE);
    hash_start = (state == pinlk_pkg::S_IDLE) && in_accept && need_check;
    out_load   = (state == pinlk_pkg::S_PUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pinlk_pkg::S_IDLE;
      digit_count   <= '0;
      attempt_count <= 4'd0;
      lock_flag     <= 1'b0;
      lock_counter  <= 8'd0;
    end else begin
      state <= state_next;
      if ((state == pinlk_pkg::S_IDLE && in_accept) || state == pinlk_pkg::S_CHECK) begin
        digit_count   <= digit_count_next;
        attempt_count <= attempt_count_next;
        lock_flag     <= lock_flag_next;
        lock_counter  <= lock_counter_next;
      end
    end
  end

  // Pending status and the digit store carry no reset.
  always_ff @(posedge clk) begin
    if ((state == pinlk_pkg::S_IDLE && in_accept) || state == pinlk_pkg::S_CHECK) begin
      pend_status <= pend_status_next;
    end
    if (state == pinlk_pkg::S_IDLE && in_accept && store_we) begin
      digit_store[digit_count[IdxW-1:0]] <= key_digit;
    end
  end

  // Result register: holds the beat until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= pend_status;
      digits_held    <= 3'(digit_count);
      attempts_used  <= attempt_count;
      is_locked      <= lock_flag;
      lock_remaining <= lock_counter;
    end
  end

  // Serial FNV-1a hash over the held digits.
  pinlk_hash #(
    .PIN_DIGITS(PIN_DIGITS)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .digit (digit_store[hash_idx]),
    .idx   (hash_idx),
    .res   (hash_res)
  );

endmodule

// ===== rtl/pinlk_checker.sv =====
`include "assert_macros.svh"

module pinlk_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [2:0] digits_held,
  input logic [3:0] attempts_used,
  input logic       is_locked,
  input logic [7:0] lock_remaining
);

  // A stalled result beat stays put.
  `PINLK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(attempts_used) && $stable(lock_remaining), "result beat changed while stalled")

  // Without a lockout there is nothing left to count down.
  `PINLK_ASSERT(a_unlocked_zero, out_valid && !is_locked, lock_remaining == 8'd0, "lock ticks left while unlocked")

  // A lockout always begins after the digits were cleared by a check.
  `PINLK_ASSERT(a_locked_empty, out_valid && is_locked, digits_held == 3'd0, "digits held during lockout")

  // Access granted leaves a clean slate.
  `PINLK_ASSERT(a_granted_clean, out_valid && status == pinlk_pkg::STS_GRANTED, !is_locked && attempts_used == 4'd0 && digits_held == 3'd0, "granted beat with stale state")

  // Unlocking clears the lockout and the attempt count together.
  `PINLK_ASSERT(a_unlock_clean, out_valid && status == pinlk_pkg::STS_UNLOCKED, !is_locked && attempts_used == 4'd0 && lock_remaining == 8'd0, "unlock beat with stale state")

endmodule

bind pin_entry_lockout_controller_unit pinlk_checker u_pinlk_checker (.*);
